>>> design/deqs_pkg.sv
`default_nettype none

package deqs_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;  // transaction accepted, apply the operation
    logic srch;  // search sweep step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic search_done;
  } stat_t;

endpackage

`default_nettype wire

>>> design/deqs_ctrl.sv
`default_nettype none

module deqs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire deqs_pkg::stat_t stat_i,
  output deqs_pkg::cmd_t     cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_RDFB = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // a new transaction may enter while the previous result is shown
  assign busy_o = (state_q != S_IDLE) && (state_q != S_RESP);
  assign done_o = (state_q == S_RESP);
  assign accept = start_i && !busy_o;

  assign cmd_o.exec = accept;
  assign cmd_o.srch = (state_q == S_SRCH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_RESP: begin
        if (accept) begin
          state_d = stat_i.is_search ? S_SRCH : S_RDFB;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SRCH: begin
        if (stat_i.search_done) begin
          state_d = S_RDFB;
        end
      end
      S_RDFB: begin
        state_d = S_RESP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/deqs_dpath.sv
`default_nettype none

module deqs_dpath #(
  parameter int unsigned DEPTH = deqs_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire deqs_pkg::cmd_t                      cmd_i,
  input  wire logic        [deqs_pkg::KIND_W-1:0]  kind_i,
  input  wire logic signed [deqs_pkg::DATA_W-1:0]  value_i,
  output deqs_pkg::stat_t                          stat_o,
  output logic             [deqs_pkg::STAT_W-1:0]  status_o,
  output logic                                     found_o,
  output logic signed      [deqs_pkg::DATA_W-1:0]  front_value_o,
  output logic signed      [deqs_pkg::DATA_W-1:0]  back_value_o,
  output logic             [deqs_pkg::COUNT_W-1:0] entry_count_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = deqs_pkg::DATA_W;

  logic [DW-1:0] mem_q [DEPTH];

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [deqs_pkg::STAT_W-1:0] status_q, status_d;
  logic          found_q, found_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          cmp_v_q, cmp_v_d;
  logic [DW-1:0] value_q;
  logic [DW-1:0] rd_a_q, rd_b_q;

  logic          full, empty;
  logic [IW-1:0] front_inc, front_dec, ptr_inc, tail_idx, back_idx;
  logic [SW-1:0] tail_sum;
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] addr_a;

  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);

  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign ptr_inc   = (ptr_q == IW'(DEPTH - 1)) ? '0 : ptr_q + IW'(1);

  // slot just past the back; back sits one before it
  assign tail_sum = SW'(front_q) + SW'(cnt_q);
  assign tail_idx = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign back_idx = (tail_idx == '0) ? IW'(DEPTH - 1) : tail_idx - IW'(1);

  always_comb begin
    front_d  = front_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = tail_idx;
    if (cmd_i.exec) begin
      status_d = deqs_pkg::ST_DONE;
      case (kind_i)
        deqs_pkg::KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = deqs_pkg::ST_FULL;
          end else begin
            front_d = front_dec;
            waddr   = front_dec;
            we      = 1'b1;
            cnt_d   = cnt_q + CW'(1);
          end
        end
        deqs_pkg::KIND_PUSH_BACK: begin
          if (full) begin
            status_d = deqs_pkg::ST_FULL;
          end else begin
            waddr = tail_idx;
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
        end
        deqs_pkg::KIND_POP_FRONT: begin
          if (empty) begin
            status_d = deqs_pkg::ST_EMPTY;
          end else begin
            front_d = front_inc;
            cnt_d   = cnt_q - CW'(1);
          end
        end
        deqs_pkg::KIND_POP_BACK: begin
          if (empty) begin
            status_d = deqs_pkg::ST_EMPTY;
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // search sweep: one read issued per cycle, compared in the next cycle
  always_comb begin
    ptr_d   = ptr_q;
    iss_d   = iss_q;
    cmp_v_d = 1'b0;
    found_d = found_q;
    if (cmd_i.exec) begin
      ptr_d   = front_q;
      iss_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.srch) begin
      if ((iss_q != cnt_q) && !found_q) begin
        cmp_v_d = 1'b1;
        ptr_d   = ptr_inc;
        iss_d   = iss_q + CW'(1);
      end
      if (cmp_v_q && (rd_a_q == value_q)) begin
        found_d = 1'b1;
      end
    end
  end

  assign addr_a = cmd_i.srch ? ptr_q : front_q;

  assign stat_o.is_search   = (kind_i == deqs_pkg::KIND_SEARCH);
  assign stat_o.search_done = found_q || ((iss_q == cnt_q) && !cmp_v_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= value_i;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[back_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      cnt_q    <= '0;
      status_q <= deqs_pkg::ST_DONE;
      found_q  <= 1'b0;
      ptr_q    <= '0;
      iss_q    <= '0;
      cmp_v_q  <= 1'b0;
    end else begin
      front_q  <= front_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      found_q  <= found_d;
      ptr_q    <= ptr_d;
      iss_q    <= iss_d;
      cmp_v_q  <= cmp_v_d;
    end
  end

  assign status_o      = status_q;
  assign found_o       = found_q;
  assign front_value_o = empty ? '0 : $signed(rd_a_q);
  assign back_value_o  = empty ? '0 : $signed(rd_b_q);
  assign entry_count_o = deqs_pkg::COUNT_W'(cnt_q);

endmodule

`default_nettype wire

>>> design/double_ended_queue_with_search_core.sv
// Deque of signed 32-bit values in a DEPTH-entry ring, with front-to-back search.
// Push/pop/no-op go from start through state RDFB to done; a search first sweeps
// the stored values in state SRCH through one memory read port, until a match or the end.
// Throughput: a new transaction may be started in the cycle done is high.
// Reset (rst_ni low, async) empties the deque; memory contents are not cleared.
// The done strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module double_ended_queue_with_search_core #(
  parameter int unsigned DEPTH = deqs_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic        [deqs_pkg::KIND_W-1:0]  kind_i,
  input  wire logic signed [deqs_pkg::DATA_W-1:0]  value_i,
  output logic                                     done_o,
  output logic             [deqs_pkg::STAT_W-1:0]  status_o,
  output logic                                     found_o,
  output logic signed      [deqs_pkg::DATA_W-1:0]  front_value_o,
  output logic signed      [deqs_pkg::DATA_W-1:0]  back_value_o,
  output logic             [deqs_pkg::COUNT_W-1:0] entry_count_o
);

  deqs_pkg::cmd_t  cmd;
  deqs_pkg::stat_t stat;

  deqs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  deqs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .found_o       (found_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o)
  );

endmodule

`default_nettype wire

>>> sim/double_ended_queue_with_search_core_tb.sv
module double_ended_queue_with_search_core_tb;
  import deqs_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_DEPTH;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    int unsigned              idle_pct;
    bit                       hold;  // wait for all outstanding results first
  } deque_op_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_W-1:0]       entry_count;
    longint unsigned          accepted_at;
  } deque_view_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [KIND_W-1:0]          kind_i;
  logic signed [DATA_W-1:0]   value_i;
  logic                       done_o;
  logic [STAT_W-1:0]          status_o;
  logic                       found_o;
  logic signed [DATA_W-1:0]   front_value_o;
  logic signed [DATA_W-1:0]   back_value_o;
  logic [COUNT_W-1:0]         entry_count_o;

  double_ended_queue_with_search_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .entry_count_o(entry_count_o)
  );

  // shadow deque
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_fill;

  deque_op_t   pending_ops[$];
  deque_view_t expected_views[$];
  int          ops_total;
  int          ops_accepted;
  int          results_seen;
  int          failures;
  int          full_rejects;
  int          empty_pops;
  int          search_hits;
  int          search_misses;
  int          peak_fill;

  logic signed [DATA_W-1:0] value_pool [24];

  function automatic deque_view_t deque_apply(logic [KIND_W-1:0] kind,
                                              logic [DATA_W-1:0] value);
    deque_view_t v;
    int unsigned i;
    v.status = ST_DONE;
    v.found  = 1'b0;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          v.status = ST_FULL;
          full_rejects++;
        end else if (kind == KIND_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = value;
          ring_fill++;
        end else begin
          ring_mem[(ring_head + ring_fill) % DEPTH] = value;
          ring_fill++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (ring_fill == 0) begin
          v.status = ST_EMPTY;
          empty_pops++;
        end else begin
          if (kind == KIND_POP_FRONT) ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      KIND_SEARCH: begin
        for (i = 0; i < ring_fill; i++) begin
          if (ring_mem[(ring_head + i) % DEPTH] == value) v.found = 1'b1;
        end
        if (v.found) search_hits++;
        else search_misses++;
      end
      default: ;
    endcase
    if (ring_fill == 0) begin
      v.front_value = '0;
      v.back_value  = '0;
    end else begin
      v.front_value = ring_mem[ring_head];
      v.back_value  = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
    end
    if (ring_fill > peak_fill) peak_fill = ring_fill;
    v.entry_count = COUNT_W'(ring_fill);
    v.accepted_at = $time;
    return v;
  endfunction

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                          int unsigned idle_pct, bit hold);
    deque_op_t op;
    op.kind     = kind;
    op.value    = value;
    op.idle_pct = idle_pct;
    op.hold     = hold;
    pending_ops.push_back(op);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 65) return value_pool[$urandom_range(23)];
    return $urandom;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // driver: start stays up while busy, so a held transaction is never dropped
  always @(posedge clk_i) begin : drive_ops
    logic accepted;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      accepted = start_i && !busy_o;
      if (accepted) begin
        void'(pending_ops.pop_front());
        expected_views.push_back(deque_apply(kind_i, value_i));
        ops_accepted <= ops_accepted + 1;
      end
      if (start_i && !accepted) begin
        // hold current transaction
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].hold &&
                     (ops_accepted + accepted != results_seen || busy_o)) &&
                   $urandom_range(99) >= pending_ops[0].idle_pct) begin
        start_i <= 1'b1;
        kind_i  <= pending_ops[0].kind;
        value_i <= pending_ops[0].value;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: an expectation made at this same edge cannot be due yet
  always @(posedge clk_i) begin : check_results
    deque_view_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (expected_views.size() == 0 || expected_views[0].accepted_at == $time) begin
        $error("result with no transaction waiting");
        failures++;
      end else begin
        want = expected_views.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          failures++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          failures++;
        end
        if (front_value_o !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, front_value_o);
          failures++;
        end
        if (back_value_o !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value, back_value_o);
          failures++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
          failures++;
        end
      end
    end
  end

  initial begin : run
    int unsigned       idle_by_phase [4];
    int                phase;
    int                n;
    int                j;
    int                len;
    int                mode;
    int                r;
    int                push_pct;
    bit                first;
    logic [KIND_W-1:0] k;
    logic [DATA_W-1:0] v;

    start_i = 1'b0;
    kind_i  = '0;
    value_i = '0;
    rst_ni  = 1'b0;
    ring_head = 0;
    ring_fill = 0;
    idle_by_phase = '{0, 85, 36, 0};

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (j = 4; j < 24; j++) value_pool[j] = $urandom;

    // directed: empty store, extremes, every kind including unused codes
    queue_op(KIND_POP_FRONT,  32'h1234_5678, 0, 0);
    queue_op(KIND_POP_BACK,   32'h8765_4321, 0, 0);
    queue_op(KIND_SEARCH,     32'h0000_0000, 0, 0);
    queue_op(KIND_PUSH_FRONT, 32'h8000_0000, 0, 0);
    queue_op(KIND_PUSH_BACK,  32'h7FFF_FFFF, 0, 0);
    queue_op(KIND_SEARCH,     32'h8000_0000, 0, 0);
    queue_op(KIND_SEARCH,     32'h7FFF_FFFF, 0, 0);
    queue_op(KIND_SEARCH,     32'h0000_0000, 0, 0);
    queue_op(KIND_PUSH_FRONT, 32'h0000_0000, 0, 0);
    queue_op(KIND_PUSH_BACK,  32'hFFFF_FFFF, 0, 0);
    queue_op(KIND_SEARCH,     32'hFFFF_FFFF, 0, 0);
    queue_op(3'd5,            32'hAAAA_AAAA, 0, 0);
    queue_op(3'd6,            32'h5555_5555, 0, 0);
    queue_op(3'd7,            32'hFFFF_FFFF, 0, 0);
    queue_op(KIND_POP_BACK,   32'h0000_0000, 0, 0);
    queue_op(KIND_POP_FRONT,  32'h0000_0000, 0, 0);
    queue_op(KIND_POP_FRONT,  32'h0000_0000, 0, 0);
    queue_op(KIND_SEARCH,     32'h0000_0000, 0, 0);
    queue_op(KIND_POP_BACK,   32'h0000_0000, 0, 0);
    queue_op(KIND_POP_BACK,   32'h0000_0000, 0, 0);
    queue_op(KIND_SEARCH,     32'h7FFF_FFFF, 0, 0);

    // random bursts: fills, drains, mixed traffic and raw noise
    for (phase = 0; phase < 4; phase++) begin
      n = 0;
      first = 1'b1;
      while (n < 400) begin
        mode     = first ? 0 : $urandom_range(3);
        len      = first ? 70 : $urandom_range(8, 72);
        push_pct = (first && phase == 0) ? 100 : 90;
        for (j = 0; j < len; j++) begin
          r = $urandom_range(99);
          v = pick_value();
          case (mode)
            0: k = (r < push_pct) ? ($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT)
                                  : KIND_SEARCH;
            1: k = (r < 85) ? ($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT)
                            : KIND_SEARCH;
            2: begin
              if (r < 35) k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
              else if (r < 60) k = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
              else if (r < 95) k = KIND_SEARCH;
              else k = KIND_W'($urandom_range(5, 7));
            end
            default: begin
              k = KIND_W'($urandom_range(7));
              v = $urandom;
            end
          endcase
          queue_op(k, v, idle_by_phase[phase], first && j == 0 && phase != 0);
          n++;
        end
        first = 1'b0;
      end
    end
    ops_total = pending_ops.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_accepted != ops_total || results_seen != ops_accepted) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      $error("%0d expected results never arrived", expected_views.size());
      failures++;
    end

    $display("Ran %0d transactions over all kinds, peak fill %0d of %0d entries.",
             ops_accepted, peak_fill, DEPTH);
    $display("Pushes rejected when full: %0d, pops on empty: %0d, searches hit/miss: %0d/%0d.",
             full_rejects, empty_pops, search_hits, search_misses);
    if (failures == 0) begin
      $display("double_ended_queue_with_search_core_tb OK");
    end else begin
      $display("double_ended_queue_with_search_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 1_000_000);
    $display("double_ended_queue_with_search_core_tb NOT OK");
    $finish;
  end

endmodule
